// ----- hdl/sla_pkg.sv -----
// ---------------------------------------------------------------------------
// sla_pkg
// Shared types and constants of the subsumption layer arbiter.
// ---------------------------------------------------------------------------
package sla_pkg;

  // field widths
  localparam int TIME_W  = 32;
  localparam int TMO_W   = 16;
  localparam int CNT_W   = 4;
  localparam int LAYER_W = 3;
  localparam int WORD_W  = 64;
  localparam int MODE_W  = 2;
  localparam int RGB_W   = 24;
  localparam int CFG_W   = 16;
  localparam int IDX_W   = 1;

  // largest layer count the fields can carry
  localparam int FIELD_LIMIT = 8;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_LAYER_COUNT = 1'b0;
  localparam logic [IDX_W-1:0] REG_TIMEOUT     = 1'b1;

  // reset values of the configuration registers
  localparam logic [CNT_W-1:0] RST_LAYER_COUNT = 4'd2;
  localparam logic [TMO_W-1:0] RST_TIMEOUT     = 16'd1000;

  // light patterns
  localparam logic [MODE_W-1:0] LIGHT_BLINK = 2'd0;
  localparam logic [MODE_W-1:0] LIGHT_FILL  = 2'd1;
  localparam logic [MODE_W-1:0] LIGHT_WAFT  = 2'd2;

  localparam logic [RGB_W-1:0] RGB_ORANGE = 24'hFFA500;
  localparam logic [RGB_W-1:0] RGB_RED    = 24'hFF0000;
  localparam logic [RGB_W-1:0] RGB_BLUE   = 24'h0000FF;

  // one stored layer entry as seen by the age check
  typedef struct packed {
    logic              heard;
    logic [TIME_W-1:0] stamp;
  } sla_entry_t;

  // limit a layer count to 1..lim
  function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] cnt,
                                                   input logic [CNT_W-1:0] lim);
    logic [CNT_W-1:0] c;
    c = cnt;
    if (c == '0) c = 4'd1;
    if (c > lim) c = lim;
    return c;
  endfunction

endpackage

// ----- hdl/sla_layer_store.sv -----
// ---------------------------------------------------------------------------
// sla_layer_store
// Per-layer last-heard time and heard flag, one write and one read port.
// ---------------------------------------------------------------------------
module sla_layer_store #(
  parameter int NUM_LAYERS = 8,
  parameter int IW         = 3
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       clr_i,
  input  logic                       wr_en_i,
  input  logic [IW-1:0]              wr_idx_i,
  input  logic [sla_pkg::TIME_W-1:0] wr_time_i,
  input  logic [IW-1:0]              rd_idx_i,
  output sla_pkg::sla_entry_t        rd_entry_o
);
  import sla_pkg::*;

  logic [TIME_W-1:0]     stamp_q [NUM_LAYERS];
  logic [NUM_LAYERS-1:0] heard_q;

  // heard flags, cleared on reset and on reconfiguration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heard_q <= '0;
    end else if (clr_i) begin
      heard_q <= '0;
    end else if (wr_en_i) begin
      heard_q[wr_idx_i] <= 1'b1;
    end
  end

  // time stamps, only meaningful while the flag is set
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      stamp_q[wr_idx_i] <= wr_time_i;
    end
  end

  // read port
  assign rd_entry_o.heard = heard_q[rd_idx_i];
  assign rd_entry_o.stamp = stamp_q[rd_idx_i];

endmodule

// ----- hdl/sla_age_check.sv -----
// ---------------------------------------------------------------------------
// sla_age_check
// Shared liveness unit: wrapping age subtract and timeout compare.
// ---------------------------------------------------------------------------
module sla_age_check (
  input  sla_pkg::sla_entry_t        entry_i,
  input  logic [sla_pkg::TIME_W-1:0] now_i,
  input  logic [sla_pkg::TMO_W-1:0]  timeout_i,
  output logic                       alive_o
);
  import sla_pkg::*;

  logic [TIME_W-1:0] age;

  // age modulo 2^32, alive while strictly below the timeout
  assign age     = now_i - entry_i.stamp;
  assign alive_o = entry_i.heard && (age < TIME_W'(timeout_i));

endmodule

// ----- hdl/subsumption_layer_arbiter.sv -----
// ---------------------------------------------------------------------------
// subsumption_layer_arbiter
// Fixed-priority layer arbiter with liveness timeout and light reporting.
// ---------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  in        input      in_valid_i / in_ready_o   source_layer, time_ms, command_word
//  out       output     out_valid_o / out_ready_i forward_valid, forwarded_word,
//                                                 current_layer, light_change,
//                                                 light_mode, light_rgb
//  cfg       input      cfg_we_i                  cfg_index_i, cfg_data_i
//
//  A request from a layer in use is passed to the age check, which visits layers
//  0..source_layer one per cycle, lowest first until a live one. A request from
//  a layer not in use goes straight to the output register.
//  The input is ready only while the sequencer is idle; a finished result waits
//  in the output register and the sequencer holds in its last state while that
//  register is full and not taken.
//  Reset clears heard flags and sets the active layer to the reset count - 1.
module subsumption_layer_arbiter #(
  parameter int MAX_LAYERS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [sla_pkg::IDX_W-1:0]           cfg_index_i,
  input  logic [sla_pkg::CFG_W-1:0]           cfg_data_i,
  // input requests
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [sla_pkg::LAYER_W-1:0]         source_layer_i,
  input  logic [sla_pkg::TIME_W-1:0]          time_ms_i,
  input  logic [sla_pkg::WORD_W-1:0]          command_word_i,
  // results
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                forward_valid_o,
  output logic [sla_pkg::WORD_W-1:0]          forwarded_word_o,
  output logic [sla_pkg::LAYER_W-1:0]         current_layer_o,
  output logic                                light_change_o,
  output logic [sla_pkg::MODE_W-1:0]          light_mode_o,
  output logic [sla_pkg::RGB_W-1:0]           light_rgb_o
);
  import sla_pkg::*;

  localparam int LIM     = (MAX_LAYERS < FIELD_LIMIT) ? MAX_LAYERS : FIELD_LIMIT;
  localparam int LW      = (LIM > 1) ? $clog2(LIM) : 1;
  localparam int RST_CNT = (LIM < 2) ? LIM : 2;
  localparam logic [LW-1:0]    ACTIVE_RST = LW'(RST_CNT - 1);
  localparam logic [CNT_W-1:0] CNT_LIM    = CNT_W'(LIM);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [CNT_W-1:0]  layer_count_q;
  logic [TMO_W-1:0]  timeout_q;
  logic [LW-1:0]     active_q, active_d;
  logic [LW-1:0]     walk_q, walk_d;
  logic              change_q, change_d;
  logic              ignored_q;
  logic [LW-1:0]     src_q;
  logic [TIME_W-1:0] now_q;
  logic [WORD_W-1:0] word_q;

  logic              out_valid_q;
  logic              fwd_q;
  logic [WORD_W-1:0] fwd_word_q;
  logic [LW-1:0]     cur_layer_q;
  logic              light_chg_q;
  logic [MODE_W-1:0] light_mode_q;
  logic [RGB_W-1:0]  light_rgb_q;

  logic [CNT_W-1:0]  eff_cnt, eff_m1, new_m1;
  logic              src_in_use, in_accept, cnt_write, out_load, alive;
  logic              fwd_d;
  logic [MODE_W-1:0] mode_d;
  logic [RGB_W-1:0]  rgb_d;
  sla_entry_t        rd_entry;

  // effective layer count and its limits
  assign eff_cnt    = clamp_count(layer_count_q, CNT_LIM);
  assign eff_m1     = eff_cnt - 4'd1;
  assign new_m1     = clamp_count(cfg_data_i[CNT_W-1:0], CNT_LIM) - 4'd1;
  assign src_in_use = {1'b0, source_layer_i} < eff_cnt;
  assign in_ready_o = (state_q == S_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;
  assign cnt_write  = cfg_we_i && (cfg_index_i == REG_LAYER_COUNT);
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  // layer time store
  sla_layer_store #(
    .NUM_LAYERS (LIM),
    .IW         (LW)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clr_i      (cnt_write),
    .wr_en_i    (in_accept && src_in_use),
    .wr_idx_i   (source_layer_i[LW-1:0]),
    .wr_time_i  (time_ms_i),
    .rd_idx_i   (walk_q),
    .rd_entry_o (rd_entry)
  );

  // shared age check, one layer per cycle
  sla_age_check u_age (
    .entry_i   (rd_entry),
    .now_i     (now_q),
    .timeout_i (timeout_q),
    .alive_o   (alive)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layer_count_q <= RST_LAYER_COUNT;
      timeout_q     <= RST_TIMEOUT;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_LAYER_COUNT: layer_count_q <= cfg_data_i[CNT_W-1:0];
        REG_TIMEOUT:     timeout_q     <= cfg_data_i;
        default:         timeout_q     <= timeout_q;
      endcase
    end
  end

  // sequencer: accept, walk layers from 0, wait for the output register
  always_comb begin
    state_d  = state_q;
    walk_d   = walk_q;
    active_d = active_q;
    change_d = change_q;
    if (cnt_write) begin
      active_d = new_m1[LW-1:0];
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          walk_d   = '0;
          change_d = 1'b0;
          state_d  = src_in_use ? S_WALK : S_DONE;
        end
      end
      S_WALK: begin
        if (alive) begin
          change_d = (walk_q != active_q);
          active_d = walk_q;
          state_d  = S_DONE;
        end else if (walk_q == src_q) begin
          state_d = S_DONE;
        end else begin
          walk_d = walk_q + 1'b1;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      active_q <= ACTIVE_RST;
      change_q <= 1'b0;
      walk_q   <= '0;
    end else begin
      state_q  <= state_d;
      active_q <= active_d;
      change_q <= change_d;
      walk_q   <= walk_d;
    end
  end

  // held request
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      ignored_q <= !src_in_use;
      src_q     <= source_layer_i[LW-1:0];
      now_q     <= time_ms_i;
      word_q    <= command_word_i;
    end
  end

  // result fields
  always_comb begin
    fwd_d  = !ignored_q && (src_q == active_q);
    mode_d = LIGHT_BLINK;
    rgb_d  = '0;
    if (change_q) begin
      priority if (active_q == '0) begin
        mode_d = LIGHT_BLINK;
        rgb_d  = RGB_ORANGE;
      end else if (active_q == LW'(1)) begin
        mode_d = LIGHT_FILL;
        rgb_d  = RGB_RED;
      end else begin
        mode_d = LIGHT_WAFT;
        rgb_d  = RGB_BLUE;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      fwd_q        <= fwd_d;
      fwd_word_q   <= fwd_d ? word_q : '0;
      cur_layer_q  <= active_q;
      light_chg_q  <= change_q;
      light_mode_q <= mode_d;
      light_rgb_q  <= rgb_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign forward_valid_o  = fwd_q;
  assign forwarded_word_o = fwd_word_q;
  assign current_layer_o  = LAYER_W'(cur_layer_q);
  assign light_change_o   = light_chg_q;
  assign light_mode_o     = light_mode_q;
  assign light_rgb_o      = light_rgb_q;

  // checks
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> !in_ready_o)
    else $error("accepted request did not make the block busy");

  a_active_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q <= eff_m1[LW-1:0])
    else $error("active layer outside the layers in use");

  a_walk_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> (walk_q <= src_q))
    else $error("walk went past the sending layer");

  a_quiet_light: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !light_change_o) |-> (light_rgb_o == '0 && light_mode_o == LIGHT_BLINK))
    else $error("light pattern without a layer change");

endmodule

// ----- tb/subsumption_layer_arbiter_tb.sv -----
// ---------------------------------------------------------------------------
// subsumption_layer_arbiter_tb
// Self-checking bench for the layer arbiter. Commands from a queue go through
// a valid/ready driver with random idle bursts. A predictor keeps its own copy
// of the layer times, heard flags, active layer and registers. The monitor
// compares every result field by field against the oldest prediction.
// ---------------------------------------------------------------------------
module subsumption_layer_arbiter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sla_pkg::*;

  localparam int LAYERS = 8;

  typedef struct packed {
    logic [LAYER_W-1:0] layer;
    logic [TIME_W-1:0]  stamp;
    logic [WORD_W-1:0]  word;
  } command_t;

  typedef struct packed {
    logic               fwd;
    logic [WORD_W-1:0]  word;
    logic [LAYER_W-1:0] layer;
    logic               change;
    logic [MODE_W-1:0]  mode;
    logic [RGB_W-1:0]   rgb;
  } grant_t;

  // clock, reset and block ports
  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               cfg_we         = 1'b0;
  logic [IDX_W-1:0]   cfg_index      = '0;
  logic [CFG_W-1:0]   cfg_data       = '0;
  logic               in_valid       = 1'b0;
  logic               in_ready;
  logic [LAYER_W-1:0] source_layer   = '0;
  logic [TIME_W-1:0]  time_ms        = '0;
  logic [WORD_W-1:0]  command_word   = '0;
  logic               out_valid;
  logic               out_ready      = 1'b0;
  logic               forward_valid;
  logic [WORD_W-1:0]  forwarded_word;
  logic [LAYER_W-1:0] current_layer;
  logic               light_change;
  logic [MODE_W-1:0]  light_mode;
  logic [RGB_W-1:0]   light_rgb;

  // predictor state
  logic [TIME_W-1:0]  model_stamp [LAYERS];
  logic               model_heard [LAYERS];
  logic [LAYER_W-1:0] model_active;
  logic [CNT_W-1:0]   model_count;
  logic [TMO_W-1:0]   model_timeout;

  // bench bookkeeping
  command_t           command_q [$];
  grant_t             pending_grants [$];
  logic [TIME_W-1:0]  clock_ms = '0;
  bit                 in_taken = 1'b0;
  bit                 quiet = 1'b0;
  int                 gap_left = 0;
  int                 stall_left = 0;
  int                 mismatches = 0;
  int                 n_sent = 0;
  int                 n_checked = 0;
  int                 n_forwarded = 0;
  int                 n_changes = 0;
  int                 n_writes = 0;

  subsumption_layer_arbiter #(
    .MAX_LAYERS(LAYERS)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .source_layer_i  (source_layer),
    .time_ms_i       (time_ms),
    .command_word_i  (command_word),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .forward_valid_o (forward_valid),
    .forwarded_word_o(forwarded_word),
    .current_layer_o (current_layer),
    .light_change_o  (light_change),
    .light_mode_o    (light_mode),
    .light_rgb_o     (light_rgb)
  );

  always #10 clk_i = ~clk_i;

  // layer count as the block uses it, limited to 1..lim
  function automatic int live_count();
    int lim;
    int c;
    lim = (LAYERS < FIELD_LIMIT) ? LAYERS : FIELD_LIMIT;
    c = int'(model_count);
    if (c < 1) c = 1;
    if (c > lim) c = lim;
    return c;
  endfunction

  // clear heard flags and park on the last layer in use
  function automatic void restart_layers();
    for (int i = 0; i < LAYERS; i++) model_heard[i] = 1'b0;
    model_active = LAYER_W'(live_count() - 1);
  endfunction

  // for a sender in use: record it, walk from layer 0 up to it, pick the first live one
  function automatic grant_t arbitrate(command_t c);
    grant_t g;
    logic [TIME_W-1:0] age;
    bit found;
    int i;
    g = '0;
    found = 1'b0;
    if (c.layer < live_count()) begin
      model_stamp[c.layer] = c.stamp;
      model_heard[c.layer] = 1'b1;
      for (i = 0; i <= c.layer && !found; i++) begin
        age = c.stamp - model_stamp[i];
        if (model_heard[i] && age < {16'd0, model_timeout}) begin
          found = 1'b1;
          if (i != model_active) g.change = 1'b1;
          model_active = LAYER_W'(i);
        end
      end
      if (c.layer == model_active) begin
        g.fwd  = 1'b1;
        g.word = c.word;
      end
      if (g.change) begin
        case (model_active)
          3'd0: begin g.mode = LIGHT_BLINK; g.rgb = RGB_ORANGE; end
          3'd1: begin g.mode = LIGHT_FILL;  g.rgb = RGB_RED;    end
          default: begin g.mode = LIGHT_WAFT; g.rgb = RGB_BLUE; end
        endcase
      end
    end
    g.layer = model_active;
    return g;
  endfunction

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      $display("%0t ns: %s expected %0h actual %0h", $time, name, exp_v, act_v);
    end
  endfunction

  // request driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (command_q.size() > 0) begin
        command_t c;
        c = command_q.pop_front();
        source_layer <= c.layer;
        time_ms      <= c.stamp;
        command_word <= c.word;
        in_valid     <= 1'b1;
        if (!quiet && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 10);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result ready with stall bursts
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if (!quiet && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 10);
    end
  end

  // monitor: predict on accepted requests, compare on accepted results
  always @(posedge clk_i) begin
    in_taken <= rst_ni && in_valid && in_ready;
    if (rst_ni) begin
      if (in_valid && in_ready) begin
        pending_grants = {pending_grants,
                          arbitrate(command_t'{source_layer, time_ms, command_word})};
        n_sent++;
      end
      if (out_valid && out_ready) begin
        if (pending_grants.size() == 0) begin
          mismatches++;
          $display("%0t ns: result expected none actual layer %0d word %0h",
                   $time, current_layer, forwarded_word);
        end else begin
          grant_t g;
          g = pending_grants.pop_front();
          check_field("forward_valid",  64'(g.fwd),    64'(forward_valid));
          check_field("forwarded_word", g.word,        forwarded_word);
          check_field("current_layer",  64'(g.layer),  64'(current_layer));
          check_field("light_change",   64'(g.change), 64'(light_change));
          check_field("light_mode",     64'(g.mode),   64'(light_mode));
          check_field("light_rgb",      64'(g.rgb),    64'(light_rgb));
          n_checked++;
          if (g.fwd) n_forwarded++;
          if (g.change) n_changes++;
        end
      end
    end
  end

  // register write, only issued while the block is idle
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == REG_LAYER_COUNT) begin
      model_count = data[CNT_W-1:0];
      restart_layers();
    end else begin
      model_timeout = data;
    end
    n_writes++;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // hold until every queued request has been taken and answered
  task automatic wait_idle();
    do begin
      @(negedge clk_i);
      #1;
    end while (command_q.size() != 0 || in_valid || pending_grants.size() != 0);
  endtask

  task automatic push_cmd(input logic [LAYER_W-1:0] layer, input logic [TIME_W-1:0] t,
                          input logic [WORD_W-1:0] w);
    command_q = {command_q, command_t'{layer, t, w}};
  endtask

  // random commands: mostly small time steps, some jumps, rewinds and wild times
  task automatic queue_random(input int n);
    command_t c;
    int span;
    int sel;
    for (int k = 0; k < n; k++) begin
      span = (model_timeout == 0) ? 64 : model_timeout;
      sel = $urandom_range(0, 15);
      if (sel == 0) clock_ms = $urandom;
      else if (sel == 1) clock_ms = clock_ms - $urandom_range(1, span);
      else if (sel == 2) clock_ms = clock_ms + span + $urandom_range(0, span);
      else clock_ms = clock_ms + $urandom_range(0, span / 3);
      if ($urandom_range(0, 7) == 0) c.layer = LAYER_W'($urandom_range(0, 7));
      else c.layer = LAYER_W'($urandom_range(0, live_count() - 1));
      c.stamp = clock_ms;
      c.word  = {$urandom, $urandom};
      command_q = {command_q, c};
    end
  endtask

  // watchdog
  initial begin
    #(5_000_000);
    $display("subsumption_layer_arbiter: mismatch");
    $finish;
  end

  // stimulus sequence
  initial begin
    logic [CFG_W-1:0] cnt;
    logic [CFG_W-1:0] tmo;
    model_count   = RST_LAYER_COUNT;
    model_timeout = RST_TIMEOUT;
    for (int i = 0; i < LAYERS; i++) model_stamp[i] = '0;
    restart_layers();
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: takeover, timeout expiry, unused senders, time wrap
    push_cmd(3'd1, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    push_cmd(3'd0, 32'd5, 64'h0);
    push_cmd(3'd1, 32'd10, {$urandom, $urandom});
    push_cmd(3'd2, 32'd20, {$urandom, $urandom});
    push_cmd(3'd7, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    push_cmd(3'd1, 32'd1010, {$urandom, $urandom});
    push_cmd(3'd0, 32'd1010, {$urandom, $urandom});
    push_cmd(3'd1, 32'd5, {$urandom, $urandom});
    push_cmd(3'd0, 32'hFFFF_FFF0, {$urandom, $urandom});
    push_cmd(3'd1, 32'h0000_0010, {$urandom, $urandom});
    wait_idle();

    // zero timeout: times recorded, nothing ever alive
    write_reg(REG_LAYER_COUNT, 16'h0008);
    write_reg(REG_TIMEOUT, 16'h0000);
    push_cmd(3'd3, 32'd100, {$urandom, $urandom});
    push_cmd(3'd7, 32'd100, {$urandom, $urandom});
    push_cmd(3'd0, 32'd100, {$urandom, $urandom});
    wait_idle();

    // longest timeout, fresh layers stepping down through every light pattern
    write_reg(REG_TIMEOUT, 16'hFFFF);
    write_reg(REG_LAYER_COUNT, 16'hFFF8);
    for (int i = 7; i >= 0; i--) begin
      push_cmd(LAYER_W'(i), TIME_W'(200 + i), {$urandom, $urandom});
    end
    wait_idle();

    // count of zero limits to a single layer
    write_reg(REG_LAYER_COUNT, 16'h0000);
    push_cmd(3'd0, 32'd0, {$urandom, $urandom});
    push_cmd(3'd1, 32'd0, {$urandom, $urandom});
    wait_idle();

    // random phases over several register settings
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin cnt = 16'h0008; tmo = 16'd1000; end
        1: begin cnt = 16'h0001; tmo = 16'd1; end
        2: begin cnt = 16'hA5F3; tmo = 16'd50; end
        3: begin cnt = 16'h00FF; tmo = 16'hFFFF; end
        4: begin cnt = 16'h0005; tmo = CFG_W'($urandom_range(1, 65535)); end
        default: begin cnt = 16'h0008; tmo = 16'd300; end
      endcase
      write_reg(REG_TIMEOUT, tmo);
      write_reg(REG_LAYER_COUNT, cnt);
      clock_ms = (p == 3) ? 32'hFFFF_F000 : $urandom;
      if (p == 5) quiet = 1'b1;
      if (p == 2) begin
        // sender holds off mid-phase until every result is back
        queue_random(40);
        wait_idle();
        queue_random(40);
      end else begin
        queue_random(80);
      end
      wait_idle();
    end

    repeat (20) @(negedge clk_i);
    $display("%0d commands sent over %0d register writes, %0d results checked",
             n_sent, n_writes, n_checked);
    $display("%0d commands forwarded, %0d light pattern changes", n_forwarded, n_changes);
    if (mismatches == 0) begin
      $display("subsumption_layer_arbiter: match");
    end else begin
      $display("subsumption_layer_arbiter: mismatch");
    end
    $finish;
  end

endmodule
